>>> rtl/cpcs_pkg.sv
// cpcs_pkg: shared types and constants for the closest palette color search unit
// no dependencies

package cpcs_pkg;

   localparam int PaletteEntriesDefault = 256;
   localparam int ColorWidth    = 8;
   localparam int DistWidth     = 26;
   localparam int CsrIndexWidth = 2;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_RED     = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_GREEN   = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_WEIGHT_BLUE    = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_PALETTE_PRESENT = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef struct packed {
      logic [ColorWidth-1:0] red;
      logic [ColorWidth-1:0] green;
      logic [ColorWidth-1:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [ColorWidth-1:0] red;
      logic [ColorWidth-1:0] green;
      logic [ColorWidth-1:0] blue;
   } weights_type;

   // token handed from cell to cell along the search chain
   typedef struct packed {
      logic                 valid;
      logic                 last;
      rgb_type              query;
      rgb_type              entry;
      logic [15:0]          sq_red;
      logic [15:0]          sq_green;
      logic [15:0]          sq_blue;
      logic [DistWidth-1:0] wdist;
   } chain_type;

endpackage

>>> rtl/cpcs_sq_cell.sv
// cpcs_sq_cell: one stage of the distance chain, forms squared channel differences
// depends on cpcs_pkg

module cpcs_sq_cell (
   input  logic                clock,
   input  logic                reset,
   input  cpcs_pkg::chain_type chain_in,
   output cpcs_pkg::chain_type chain_out
);
   import cpcs_pkg::*;

   chain_type chain_ff, chain_in_w;
   logic [ColorWidth-1:0] dr, dg, db;

   // absolute channel differences
   always_comb begin
      dr = (chain_in.query.red > chain_in.entry.red) ?
           chain_in.query.red - chain_in.entry.red : chain_in.entry.red - chain_in.query.red;
      dg = (chain_in.query.green > chain_in.entry.green) ?
           chain_in.query.green - chain_in.entry.green :
           chain_in.entry.green - chain_in.query.green;
      db = (chain_in.query.blue > chain_in.entry.blue) ?
           chain_in.query.blue - chain_in.entry.blue : chain_in.entry.blue - chain_in.query.blue;
      chain_in_w          = chain_in;
      chain_in_w.sq_red   = 16'(dr) * 16'(dr);
      chain_in_w.sq_green = 16'(dg) * 16'(dg);
      chain_in_w.sq_blue  = 16'(db) * 16'(db);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff       <= '0;
      end else begin
         chain_ff       <= chain_in_w;
      end
   end

   assign chain_out = chain_ff;
endmodule

>>> rtl/cpcs_wsum_cell.sv
// cpcs_wsum_cell: chain stage that weights the squares and sums them
// depends on cpcs_pkg

module cpcs_wsum_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  cpcs_pkg::weights_type weights,
   input  cpcs_pkg::chain_type   chain_in,
   output cpcs_pkg::chain_type   chain_out
);
   import cpcs_pkg::*;

   chain_type chain_ff, chain_in_w;
   logic [23:0] tr, tg, tb;

   // three narrow products and one three-term sum
   always_comb begin
      tr = 24'(chain_in.sq_red)   * 24'(weights.red);
      tg = 24'(chain_in.sq_green) * 24'(weights.green);
      tb = 24'(chain_in.sq_blue)  * 24'(weights.blue);
      chain_in_w       = chain_in;
      chain_in_w.wdist = DistWidth'(tr) + DistWidth'(tg) + DistWidth'(tb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= '0;
      end else begin
         chain_ff <= chain_in_w;
      end
   end

   assign chain_out = chain_ff;
endmodule

>>> rtl/cpcs_min_cell.sv
// cpcs_min_cell: last chain stage, keeps the running minimum and its index
// depends on cpcs_pkg

module cpcs_min_cell #(
   parameter int IndexWidth = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  cpcs_pkg::chain_type        chain_in,
   output logic                       done,
   output logic [7:0]                 best_index,
   output logic [cpcs_pkg::DistWidth-1:0] best_distance
);
   import cpcs_pkg::*;

   logic                  first_ff, first_in;
   logic [IndexWidth-1:0] idx_ff, idx_in, best_ff, best_in;
   logic [DistWidth-1:0]  dist_ff, dist_in;
   logic                  done_ff, done_in;

   // strict less-than keeps the lowest index on ties
   always_comb begin
      first_in = first_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      dist_in  = dist_ff;
      done_in  = 1'b0;
      if (chain_in.valid) begin
         if (first_ff || chain_in.wdist < dist_ff) begin
            best_in = idx_ff;
            dist_in = chain_in.wdist;
         end
         idx_in   = idx_ff + 1'b1;
         first_in = 1'b0;
         if (chain_in.last) begin
            done_in  = 1'b1;
            first_in = 1'b1;
            idx_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         first_ff <= first_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
      end
      best_ff <= best_in;
      dist_ff <= dist_in;
   end

   assign done          = done_ff;
   assign best_index    = 8'(best_ff);
   assign best_distance = dist_ff;

   // scan index returns to zero after the final entry
   assert property (@(posedge clock) disable iff (reset)
      done |-> idx_ff == '0) else $error("index not rewound");
   assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held two cycles");
   assert property (@(posedge clock) disable iff (reset)
      done |-> first_ff) else $error("first flag not restored");
endmodule

>>> rtl/closest_palette_color_search_unit.sv
// closest_palette_color_search_unit: top level, palette memory, scan control
// and result port; depends on cpcs_pkg and the three chain cell modules
//
// usage: a request transfers when start is high and busy is low. req_req_type
// selects a palette write (req_entry_index, rgb) or a query (rgb). A write
// gives no response. A query with palette_present clear answers with
// rsp_status 1 and does not scan. Otherwise the query streams every palette
// entry, one memory read per cycle, through a chain of cells (squares,
// weighted sum, running minimum); the response strobe rsp_valid rises once
// the last entry has passed the chain. busy stays high until the cycle after
// the response, so one query is in flight at a time.
// Each response is on the rsp_ ports for one cycle; the receiver cannot stall.
// Configuration writes on csr_ are always ready. Reset clears control and
// restores weights 1 and palette_present 0; the palette is undefined until
// written, and no clearing pass is needed.

module closest_palette_color_search_unit #(
   parameter int PALETTE_ENTRIES = cpcs_pkg::PaletteEntriesDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_req_type,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   output logic        rsp_status,
   output logic [7:0]  rsp_best_index,
   output logic [cpcs_pkg::DistWidth-1:0] rsp_best_distance,
   output logic        rsp_exact_match,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [cpcs_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]  csr_wdata
);
   import cpcs_pkg::*;

   localparam int AddrWidth = $clog2(PALETTE_ENTRIES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   weights_type weights_ff;
   logic present_ff;
   rgb_type query_ff, query_in;
   logic [AddrWidth-1:0] addr_ff, addr_in;
   rgb_type mem [PALETTE_ENTRIES];
   rgb_type rd_ff;
   logic rd_valid_ff, rd_last_ff;
   logic nopal_ff, nopal_in, nopal_d_ff;
   chain_type c0, c1, c2;
   logic done;
   logic [7:0] min_index;
   logic [DistWidth-1:0] min_dist;
   logic accept;
   logic rsp_valid_ff, rsp_status_ff, rsp_exact_ff;
   logic [7:0] rsp_index_ff;
   logic [DistWidth-1:0] rsp_dist_ff;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weights_ff <= '{red: 8'd1, green: 8'd1, blue: 8'd1};
         present_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_WEIGHT_RED:      weights_ff.red   <= csr_wdata;
            CSR_WEIGHT_GREEN:    weights_ff.green <= csr_wdata;
            CSR_WEIGHT_BLUE:     weights_ff.blue  <= csr_wdata;
            CSR_PALETTE_PRESENT: present_ff       <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // palette memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (accept && req_req_type == REQ_WRITE && 32'(req_entry_index) < PALETTE_ENTRIES) begin
         mem[AddrWidth'(req_entry_index)] <= '{red: req_red, green: req_green, blue: req_blue};
      end
      rd_ff <= mem[addr_ff];
   end

   // scan control
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      query_in = query_ff;
      nopal_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_req_type == REQ_QUERY) begin
               query_in = '{red: req_red, green: req_green, blue: req_blue};
               if (present_ff) begin
                  state_in = ST_SCAN;
                  addr_in  = '0;
               end else begin
                  nopal_in = 1'b1;
                  state_in = ST_WAIT;
               end
            end
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (32'(addr_ff) == PALETTE_ENTRIES - 1) begin
               addr_in  = '0;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (rsp_valid_ff) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
         nopal_ff    <= 1'b0;
         nopal_d_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= (state_ff == ST_SCAN);
         rd_last_ff  <= (state_ff == ST_SCAN) && (32'(addr_ff) == PALETTE_ENTRIES - 1);
         nopal_ff    <= nopal_in;
         nopal_d_ff  <= nopal_ff;
      end
      query_ff <= query_in;
   end

   // feed the chain of cells
   always_comb begin
      c0          = '0;
      c0.valid    = rd_valid_ff;
      c0.last     = rd_last_ff;
      c0.query    = query_ff;
      c0.entry    = rd_ff;
   end

   cpcs_sq_cell u_sq (.clock(clock), .reset(reset), .chain_in(c0), .chain_out(c1));
   cpcs_wsum_cell u_wsum (.clock(clock), .reset(reset), .weights(weights_ff),
                          .chain_in(c1), .chain_out(c2));
   cpcs_min_cell #(.IndexWidth(AddrWidth)) u_min (
      .clock(clock), .reset(reset), .chain_in(c2), .done(done),
      .best_index(min_index), .best_distance(min_dist));

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= done || nopal_d_ff;
      end
      rsp_status_ff <= nopal_d_ff;
      rsp_index_ff  <= nopal_d_ff ? 8'd0 : min_index;
      rsp_dist_ff   <= nopal_d_ff ? '0 : min_dist;
      rsp_exact_ff  <= !nopal_d_ff && (min_dist == '0);
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_best_index    = rsp_index_ff;
   assign rsp_best_distance = rsp_dist_ff;
   assign rsp_exact_match   = rsp_exact_ff;

   // a response only leaves while a query is outstanding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_WAIT) else $error("response outside a query");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !rsp_valid) else $error("response during scan");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> state_ff == ST_IDLE) else $error("busy after response");
endmodule

>>> dv/closest_palette_color_search_unit_tb.sv
// closest_palette_color_search_unit_tb: self-checking bench for the palette search unit
// depends on cpcs_pkg and closest_palette_color_search_unit

`timescale 1ns / 1ps

// predicted responses of the palette search, oldest first
class palette_search_scoreboard;
   logic [7:0]  pal_red [256];
   logic [7:0]  pal_green [256];
   logic [7:0]  pal_blue [256];
   logic [7:0]  wt_red, wt_green, wt_blue;
   logic        present;
   logic [35:0] pending [$];
   int          mismatches;
   int          responses;

   function new();
      wt_red = 8'd1;
      wt_green = 8'd1;
      wt_blue = 8'd1;
      present = 1'b0;
      mismatches = 0;
      responses = 0;
   endfunction

   function void set_csr(logic [cpcs_pkg::CsrIndexWidth-1:0] idx, logic [7:0] data);
      case (idx)
         cpcs_pkg::CSR_WEIGHT_RED:      wt_red = data;
         cpcs_pkg::CSR_WEIGHT_GREEN:    wt_green = data;
         cpcs_pkg::CSR_WEIGHT_BLUE:     wt_blue = data;
         cpcs_pkg::CSR_PALETTE_PRESENT: present = data[0];
         default: ;
      endcase
   endfunction

   function int unsigned sq_term(logic [7:0] a, logic [7:0] b, logic [7:0] w);
      int unsigned d;
      d = (a > b) ? 32'(a - b) : 32'(b - a);
      return d * d * 32'(w);
   endfunction

   // note an accepted request; queries push the closest entry or, without a palette, a status
   function void note_request(logic kind, logic [7:0] idx, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b);
      int unsigned best_d, d;
      logic [7:0]  best_i;
      if (kind == cpcs_pkg::REQ_WRITE) begin
         pal_red[idx] = r;
         pal_green[idx] = g;
         pal_blue[idx] = b;
         return;
      end
      if (!present) begin
         pending.push_back({1'b1, 8'd0, 26'd0, 1'b0});
         return;
      end
      best_d = 32'hFFFF_FFFF;
      best_i = 8'd0;
      for (int i = 0; i < 256; i++) begin
         d = sq_term(r, pal_red[i], wt_red) + sq_term(g, pal_green[i], wt_green)
             + sq_term(b, pal_blue[i], wt_blue);
         if (d < best_d) begin
            best_d = d;
            best_i = 8'(i);
         end
      end
      pending.push_back({1'b0, best_i, best_d[25:0], best_d == 0});
   endfunction

   function void report(string what, logic [31:0] got, logic [31:0] want);
      $display("error: response %0d %s got %0d expected %0d", responses, what, got, want);
      mismatches++;
   endfunction

   // compare one response with the oldest prediction
   function void check_response(logic st, logic [7:0] idx, logic [25:0] dist_v, logic ex);
      logic [35:0] e;
      responses++;
      if (pending.size() == 0) begin
         $display("error: unexpected response %0d", responses);
         mismatches++;
         return;
      end
      e = pending.pop_front();
      if (st !== e[35]) report("status", 32'(st), 32'(e[35]));
      if (idx !== e[34:27]) report("best_index", 32'(idx), 32'(e[34:27]));
      if (dist_v !== e[26:1]) report("best_distance", 32'(dist_v), 32'(e[26:1]));
      if (ex !== e[0]) report("exact_match", 32'(ex), 32'(e[0]));
   endfunction
endclass

module closest_palette_color_search_unit_tb;
   import cpcs_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_req_type = 0;
   logic [7:0]  req_entry_index = 0, req_red = 0, req_green = 0, req_blue = 0;
   logic        rsp_valid, rsp_status, rsp_exact_match;
   logic [7:0]  rsp_best_index;
   logic [DistWidth-1:0] rsp_best_distance;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = 0;
   logic [7:0]  csr_wdata = 0;

   palette_search_scoreboard sb = new();
   int          idle_pct = 0;
   int          queries = 0;
   longint      cycles = 0;

   closest_palette_color_search_unit i_dut (.*);

   always #5 clock = ~clock;

   // responses are sampled at the rising edge; run limit
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid)
         sb.check_response(rsp_status, rsp_best_index, rsp_best_distance, rsp_exact_match);
      if (cycles > 2_000_000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // one request transfer, with random idle cycles before it; start stays
   // high afterwards so a following request can go back to back
   task automatic send(logic kind, logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                       logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(negedge clock);
      end
      start <= 1;
      req_req_type <= kind;
      req_entry_index <= idx;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, idx, r, g, b);
      if (kind == REQ_QUERY) queries++;
      @(negedge clock);
   endtask

   task automatic write_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      send(REQ_WRITE, idx, r, g, b);
   endtask

   // stop sending, wait until every prediction has arrived, plus the pipeline tail
   task automatic drain();
      start <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (270) @(negedge clock);
   endtask

   task automatic write_csr(logic [CsrIndexWidth-1:0] idx, logic [7:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_csr(idx, data);
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic set_weights(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      drain();
      write_csr(CSR_WEIGHT_RED, r);
      write_csr(CSR_WEIGHT_GREEN, g);
      write_csr(CSR_WEIGHT_BLUE, b);
   endtask

   // random query, often near a palette entry
   task automatic random_query();
      int k;
      k = $urandom_range(3);
      if (k == 0)
         send(REQ_QUERY, 8'($urandom), sb.pal_red[$urandom_range(255)],
              sb.pal_green[$urandom_range(255)], sb.pal_blue[$urandom_range(255)]);
      else if (k == 1) begin
         k = $urandom_range(255);
         send(REQ_QUERY, 8'($urandom), sb.pal_red[k] ^ 8'($urandom_range(3)),
              sb.pal_green[k], sb.pal_blue[k] ^ 8'($urandom_range(1)));
      end else
         send(REQ_QUERY, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // no palette yet: status reports it
      send(REQ_QUERY, 8'hFF, 8'hFF, 8'h00, 8'hAA);
      // fill every entry; duplicates give ties
      for (int i = 0; i < 256; i++)
         write_entry(8'(i), (i % 3 == 0) ? 8'h00 : 8'($urandom), 8'($urandom),
                     (i == 255) ? 8'hFF : 8'($urandom));
      write_entry(8'd7, 8'h00, 8'h00, 8'h00);
      write_entry(8'd200, 8'h00, 8'h00, 8'h00);
      drain();
      write_csr(CSR_PALETTE_PRESENT, 8'd1);
      send(REQ_QUERY, 8'h00, 8'h00, 8'h00, 8'h00);
      send(REQ_QUERY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
      send(REQ_QUERY, 8'h55, 8'h80, 8'h7F, 8'h01);
      set_weights(8'hFF, 8'hFF, 8'hFF);
      send(REQ_QUERY, 8'hAA, 8'hFF, 8'h00, 8'hFF);
      send(REQ_QUERY, 8'h00, sb.pal_red[255], sb.pal_green[255], sb.pal_blue[255]);
      set_weights(8'h00, 8'h00, 8'h00);
      send(REQ_QUERY, 8'h00, 8'h12, 8'h34, 8'h56);
      set_weights(8'h00, 8'h01, 8'h00);
      send(REQ_QUERY, 8'h00, 8'hFF, 8'h40, 8'hFF);
      drain();
      write_csr(CSR_PALETTE_PRESENT, 8'd0);
      send(REQ_QUERY, 8'h12, 8'h40, 8'h40, 8'h40);
      drain();
      write_csr(CSR_PALETTE_PRESENT, 8'd1);

      // random phases with changing idling and weights
      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 62;
            2: idle_pct = 20;
            default: idle_pct = $urandom_range(40);
         endcase
         if (phase == 6) set_weights(8'hFF, 8'h00, 8'hFF);
         else set_weights(8'($urandom), 8'($urandom), 8'($urandom));
         if (phase == 5) begin
            drain();
            write_csr(CSR_PALETTE_PRESENT, 8'd0);
         end else if (phase == 6) begin
            drain();
            write_csr(CSR_PALETTE_PRESENT, 8'd1);
         end
         for (int n = 0; n < 125; n++) begin
            if ($urandom_range(2) == 0)
               write_entry(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
               random_query();
            // sender holds off until all responses are in
            if (n == 60) drain();
         end
      end

      drain();
      $display("covered %0d queries, %0d responses, weight and palette settings varied",
               queries, sb.responses);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
